// ===== hdl/pcc_pkg.sv =====
package pcc_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int MAX_VERTICES_DEF = 4096;
  localparam int TURN_W           = 13;
  localparam int OUT_DATA_W       = 32;
  localparam int QUEUE_DEPTH      = 4;
  // vertices carried per queue entry: older, newer, current, first, second
  localparam int VTX_PER_ENTRY    = 5;
  localparam int TRIPLES          = 3;

  typedef struct packed {
    logic has_mid;  // the running triple ending at this vertex is valid
    logic last;     // closing vertex of the polygon
    logic few_vtx;  // polygon has three or fewer vertices
  } item_flags_t;

endpackage

// ===== hdl/polygon_convexity_check_core.sv =====
// Throughput: one vertex per cycle while the queue has room; three cross-product units
// evaluate the running triple and both wrap-around triples in parallel, so closing
// vertices run at full rate. A four-entry queue between intake and arithmetic lets
// either side stall alone.
// Reset: synchronous, active-high rst empties the queue and pipe and starts a new polygon.
module polygon_convexity_check_core #(
  parameter int COORD_BITS   = pcc_pkg::COORD_BITS_DEF,
  parameter int MAX_VERTICES = pcc_pkg::MAX_VERTICES_DEF,
  parameter int IN_DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // point_x, point_y, zero padding
  input  logic [IN_DATA_W-1:0]           s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // is_convex, positive_turns, negative_turns, zero padding
  output logic [pcc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pcc_pkg::*;

  localparam int ENTRY_W = VTX_PER_ENTRY * 2 * COORD_BITS;
  localparam int Q_W     = ENTRY_W + $bits(item_flags_t);
  localparam int PAD_W   = OUT_DATA_W - 1 - 2 * TURN_W;

  logic                 push, q_full, q_empty, q_pop;
  logic [ENTRY_W-1:0]   push_verts, q_verts;
  item_flags_t          push_flags, q_flags;
  logic [Q_W-1:0]       q_rd;
  logic                 res_convex;
  logic [TURN_W-1:0]    res_pos, res_neg;

  pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_x       (s_axis_tdata[COORD_BITS-1:0]),
    .in_y       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_last    (s_axis_tlast),
    .full       (q_full),
    .push       (push),
    .push_verts (push_verts),
    .push_flags (push_flags)
  );

  pcc_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({push_flags, push_verts}),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty),
    .full    (q_full)
  );

  assign q_verts = q_rd[ENTRY_W-1:0];
  assign q_flags = item_flags_t'(q_rd[Q_W-1:ENTRY_W]);

  pcc_back #(.COORD_BITS(COORD_BITS), .MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_empty),
    .q_verts    (q_verts),
    .q_flags    (q_flags),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_convex (res_convex),
    .out_pos    (res_pos),
    .out_neg    (res_neg)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res_neg, res_pos, res_convex};

endmodule

// ===== hdl/pcc_front.sv =====
module pcc_front #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic signed [COORD_BITS-1:0]                    in_x,
  input  logic signed [COORD_BITS-1:0]                    in_y,
  input  logic                                            in_last,
  input  logic                                            full,
  output logic                                            push,
  output logic [pcc_pkg::VTX_PER_ENTRY*2*COORD_BITS-1:0]  push_verts,
  output pcc_pkg::item_flags_t                            push_flags
);
  import pcc_pkg::*;

  localparam int VTX_W = 2 * COORD_BITS;
  // vertex count only matters up to four, so it saturates there
  localparam logic [2:0] VT_SAT = 3'd4;

  logic [2:0]       vt;
  logic [VTX_W-1:0] first_v, second_v, older_v, newer_v, cur_v;
  logic             accept;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign cur_v    = {in_y, in_x};

  // a word joins the queue when it closes a triple or closes the polygon
  assign push               = accept && (vt >= 3'd2 || in_last);
  assign push_flags.has_mid = (vt >= 3'd2);
  assign push_flags.last    = in_last;
  assign push_flags.few_vtx = (vt < 3'd3);
  assign push_verts         = {second_v, first_v, cur_v, newer_v, older_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= '0;
    end else if (accept) begin
      if (in_last) begin
        vt <= '0;
      end else if (vt != VT_SAT) begin
        vt <= vt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (vt == 3'd0) begin
        first_v <= cur_v;
      end
      if (vt == 3'd1) begin
        second_v <= cur_v;
      end
      older_v <= newer_v;
      newer_v <= cur_v;
    end
  end

endmodule

// ===== hdl/pcc_queue.sv =====
module pcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);
  import pcc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == DEPTH_C);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_IDX) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_IDX) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/pcc_back.sv =====
module pcc_back #(
  parameter int COORD_BITS   = pcc_pkg::COORD_BITS_DEF,
  parameter int MAX_VERTICES = pcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            q_valid,
  input  logic [pcc_pkg::VTX_PER_ENTRY*2*COORD_BITS-1:0]  q_verts,
  input  pcc_pkg::item_flags_t                            q_flags,
  output logic                                            q_pop,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic                                            out_convex,
  output logic [pcc_pkg::TURN_W-1:0]                      out_pos,
  output logic [pcc_pkg::TURN_W-1:0]                      out_neg
);
  import pcc_pkg::*;

  localparam int VTX_W = 2 * COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_VERTICES);

  logic signed [COORD_BITS-1:0] vx [VTX_PER_ENTRY];
  logic signed [COORD_BITS-1:0] vy [VTX_PER_ENTRY];

  logic                  en;
  logic                  s1_valid, s2_valid, s3_valid;
  item_flags_t           s1_flags, s2_flags, s3_flags;
  logic signed [DW-1:0]  s1_u [TRIPLES];
  logic signed [DW-1:0]  s1_v [TRIPLES];
  logic signed [DW-1:0]  s1_s [TRIPLES];
  logic signed [DW-1:0]  s1_t [TRIPLES];
  logic signed [PW-1:0]  s2_p [TRIPLES];
  logic signed [PW-1:0]  s2_q [TRIPLES];
  logic [TRIPLES-1:0]    s3_pos, s3_neg;

  logic [CW-1:0]         cnt_pos, cnt_neg;
  logic [TRIPLES-1:0]    use_mask;
  logic [1:0]            inc_pos, inc_neg;
  logic [CW:0]           sum_pos, sum_neg;
  logic [CW-1:0]         sat_pos, sat_neg;

  // the whole pipe holds while a finished result waits
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  for (genvar i = 0; i < VTX_PER_ENTRY; i++) begin : g_unpack
    assign vx[i] = q_verts[i*VTX_W +: COORD_BITS];
    assign vy[i] = q_verts[i*VTX_W + COORD_BITS +: COORD_BITS];
  end

  // triple k is vertices k, k+1, k+2 of the entry: running, then the two wrap-arounds
  for (genvar k = 0; k < TRIPLES; k++) begin : g_tri
    always_ff @(posedge clk) begin
      if (en) begin
        s1_u[k] <= DW'(vx[k+1]) - DW'(vx[k]);
        s1_v[k] <= DW'(vy[k+2]) - DW'(vy[k+1]);
        s1_s[k] <= DW'(vy[k+1]) - DW'(vy[k]);
        s1_t[k] <= DW'(vx[k+2]) - DW'(vx[k+1]);
        s2_p[k] <= s1_u[k] * s1_v[k];
        s2_q[k] <= s1_s[k] * s1_t[k];
        s3_pos[k] <= (s2_p[k] > s2_q[k]);
        s3_neg[k] <= (s2_p[k] < s2_q[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags <= q_flags;
      s2_flags <= s1_flags;
      s3_flags <= s2_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_comb begin
    use_mask = {s3_flags.last && !s3_flags.few_vtx, s3_flags.last && !s3_flags.few_vtx,
                s3_flags.has_mid};
    inc_pos  = 2'({1'b0, s3_pos[0] & use_mask[0]}) + 2'({1'b0, s3_pos[1] & use_mask[1]})
             + 2'({1'b0, s3_pos[2] & use_mask[2]});
    inc_neg  = 2'({1'b0, s3_neg[0] & use_mask[0]}) + 2'({1'b0, s3_neg[1] & use_mask[1]})
             + 2'({1'b0, s3_neg[2] & use_mask[2]});
    sum_pos  = {1'b0, cnt_pos} + (CW + 1)'(inc_pos);
    sum_neg  = {1'b0, cnt_neg} + (CW + 1)'(inc_neg);
    sat_pos  = (sum_pos > MAX_C) ? CW'(MAX_VERTICES) : sum_pos[CW-1:0];
    sat_neg  = (sum_neg > MAX_C) ? CW'(MAX_VERTICES) : sum_neg[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_pos <= '0;
      cnt_neg <= '0;
    end else if (en && s3_valid) begin
      if (s3_flags.last) begin
        cnt_pos <= '0;
        cnt_neg <= '0;
      end else begin
        cnt_pos <= sat_pos;
        cnt_neg <= sat_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && s3_valid && s3_flags.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid && s3_flags.last) begin
      if (s3_flags.few_vtx) begin
        out_convex <= 1'b1;
        out_pos    <= '0;
        out_neg    <= '0;
      end else begin
        out_convex <= (sat_pos == '0) || (sat_neg == '0);
        out_pos    <= TURN_W'(sat_pos);
        out_neg    <= TURN_W'(sat_neg);
      end
    end
  end

endmodule

// ===== bench/tb_polygon_convexity_check_core.sv =====
`timescale 1ns / 1ps
module tb_polygon_convexity_check_core;
  import pcc_pkg::*;

  localparam int COORD_W   = COORD_BITS_DEF;
  localparam int IN_W      = ((2 * COORD_W + 7) / 8) * 8;
  localparam int TURN_MAX  = MAX_VERTICES_DEF;
  localparam int HOLD_CYC  = 400;
  localparam int TAIL_CYC  = 20;
  localparam int RAND_GOAL = 680;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef struct {
    bit              is_convex;
    bit [TURN_W-1:0] pos;
    bit [TURN_W-1:0] neg;
  } verdict_t;

  typedef enum {
    SHAPE_SCATTER, SHAPE_CONVEX, SHAPE_DENTED, SHAPE_LINE, SHAPE_CORNERS
  } shape_kind_t;

  class turn_scoreboard;
    vertex_t     first_pt, second_pt, older_pt, newer_pt;
    int unsigned seen, left_n, right_n;
    verdict_t    verdict_q[$];
    int          errors, polygons, convex_seen;

    function void clear_polygon();
      first_pt  = '0;
      second_pt = '0;
      older_pt  = '0;
      newer_pt  = '0;
      seen      = 0;
      left_n    = 0;
      right_n   = 0;
    endfunction

    function new();
      clear_polygon();
      errors = 0;
      polygons = 0;
      convex_seen = 0;
    endfunction

    // z of (b - a) x (c - b); 35 bits at most, exact in 64
    function void tally_turn(vertex_t a, vertex_t b, vertex_t c);
      longint z;
      z = (longint'(b.x) - longint'(a.x)) * (longint'(c.y) - longint'(b.y))
        - (longint'(b.y) - longint'(a.y)) * (longint'(c.x) - longint'(b.x));
      if (z > 0 && left_n < TURN_MAX) left_n++;
      if (z < 0 && right_n < TURN_MAX) right_n++;
    endfunction

    function void note_vertex(vertex_t p, bit last);
      verdict_t r;
      if (seen >= 2) tally_turn(older_pt, newer_pt, p);
      if (seen == 0) first_pt = p;
      if (seen == 1) second_pt = p;
      if (seen < TURN_MAX) seen++;
      if (!last) begin
        older_pt = newer_pt;
        newer_pt = p;
        return;
      end
      if (seen <= 3) begin
        r.is_convex = 1'b1;
        r.pos = '0;
        r.neg = '0;
      end else begin
        // close the loop: the two triples that wrap back to the start
        tally_turn(newer_pt, p, first_pt);
        tally_turn(p, first_pt, second_pt);
        r.is_convex = (left_n == 0 || right_n == 0);
        r.pos = left_n[TURN_W-1:0];
        r.neg = right_n[TURN_W-1:0];
      end
      if (r.is_convex) convex_seen++;
      polygons++;
      verdict_q = {verdict_q, r};
      clear_polygon();
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] w);
      verdict_t e;
      if (verdict_q.size() == 0) begin
        $error("result word 0x%08h with no polygon outstanding", w);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      if (w[0] !== e.is_convex) begin
        $error("is_convex: expected %0d, got %0d", e.is_convex, w[0]);
        errors++;
      end
      if (w[TURN_W:1] !== e.pos) begin
        $error("positive_turns: expected %0d, got %0d", e.pos, w[TURN_W:1]);
        errors++;
      end
      if (w[2*TURN_W:TURN_W+1] !== e.neg) begin
        $error("negative_turns: expected %0d, got %0d", e.neg, w[2*TURN_W:TURN_W+1]);
        errors++;
      end
      if (w[OUT_DATA_W-1:2*TURN_W+1] !== '0) begin
        $error("padding: expected 0, got 0x%0h", w[OUT_DATA_W-1:2*TURN_W+1]);
        errors++;
      end
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // point_x, point_y, zero padding
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // is_convex, positive_turns, negative_turns, zero padding
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  turn_scoreboard sb = new();
  vertex_t        shape[$];
  bit             calm = 1'b0;
  bit             hold_req = 1'b0;
  bit             hold_done = 1'b0;
  int             vertices_sent = 0;

  polygon_convexity_check_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_vertex(vertex_t v, bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_vertex(v, last);
    vertices_sent++;
  endtask

  task automatic send_shape();
    for (int i = 0; i < shape.size(); i++) send_vertex(shape[i], i == shape.size() - 1);
  endtask

  task automatic add_pt(int x, int y);
    vertex_t v;
    v.x = COORD_W'(x);
    v.y = COORD_W'(y);
    shape = {shape, v};
  endtask

  // drop valid and hold the sender until every outstanding verdict has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic make_shape(shape_kind_t kind, int n);
    int  corner[5];
    int  cx, cy, dx, dy, k;
    real r, a0, step;
    corner = '{-32768, -1, 0, 1, 32767};
    shape.delete();
    cx = $urandom_range(0, 20000) - 10000;
    cy = $urandom_range(0, 20000) - 10000;
    case (kind)
      SHAPE_SCATTER: begin
        for (int i = 0; i < n; i++) add_pt($urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      SHAPE_CONVEX, SHAPE_DENTED: begin
        r    = $urandom_range(1, 22000);
        a0   = $urandom_range(0, 6283) / 1000.0;
        step = 6.283185307 / n;
        if ($urandom_range(0, 1)) step = -step;
        for (int i = 0; i < n; i++)
          add_pt(cx + $rtoi(r * $cos(a0 + i * step)), cy + $rtoi(r * $sin(a0 + i * step)));
        // push one vertex to the centre to dent the outline
        if (kind == SHAPE_DENTED) begin
          k = $urandom_range(0, n - 1);
          shape[k].x = COORD_W'(cx);
          shape[k].y = COORD_W'(cy);
        end
      end
      SHAPE_LINE: begin
        dx = $urandom_range(0, 100) - 50;
        dy = $urandom_range(0, 100) - 50;
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 20) - 10;
          add_pt(cx + k * dx, cy + k * dy);
        end
      end
      default: begin
        for (int i = 0; i < n; i++)
          add_pt(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]);
      end
    endcase
  endtask

  task automatic random_polygons(int goal);
    int          start, n, pick;
    shape_kind_t kind;
    start = vertices_sent;
    while (vertices_sent - start < goal) begin
      calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = SHAPE_CONVEX;
      else if (pick < 60) kind = SHAPE_SCATTER;
      else if (pick < 75) kind = SHAPE_DENTED;
      else if (pick < 88) kind = SHAPE_LINE;
      else                kind = SHAPE_CORNERS;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      make_shape(kind, n);
      send_shape();
    end
  endtask

  task automatic directed_polygons();
    shape.delete();
    add_pt(-32768, -32768);
    send_shape();
    shape.delete();
    add_pt(32767, 32767);
    add_pt(-32768, 0);
    send_shape();
    shape.delete();
    add_pt(-32768, -32768);
    add_pt(32767, -32768);
    add_pt(0, 32767);
    send_shape();
    // full-range square, both windings
    shape.delete();
    add_pt(-32768, -32768);
    add_pt(32767, -32768);
    add_pt(32767, 32767);
    add_pt(-32768, 32767);
    send_shape();
    shape.delete();
    add_pt(-32768, 32767);
    add_pt(32767, 32767);
    add_pt(32767, -32768);
    add_pt(-32768, -32768);
    send_shape();
    // arrowhead: one reflex corner
    shape.delete();
    add_pt(0, 0);
    add_pt(10, 0);
    add_pt(5, 2);
    add_pt(10, 10);
    add_pt(0, 10);
    send_shape();
    // collinear run, every product zero
    shape.delete();
    for (int i = 0; i < 4; i++) add_pt(i, i);
    send_shape();
    shape.delete();
    for (int i = 0; i < 4; i++) add_pt(32767, -32768);
    send_shape();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_polygons();
    drain();
    random_polygons(RAND_GOAL / 2);
    // back-pressure burst: one-vertex polygons at full rate into a stalled output
    drain();
    calm = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      shape.delete();
      add_pt($urandom_range(0, 65535), $urandom_range(0, 65535));
      send_shape();
    end
    drain();
    random_polygons(RAND_GOAL / 2);
    drain();
    repeat (TAIL_CYC) @(posedge clk);
    $display("Covered %0d polygons over %0d vertices: %0d convex, %0d not convex.",
             sb.polygons, vertices_sent, sb.convex_seen, sb.polygons - sb.convex_seen);
    $display("Output held off once for %0d cycles while the input kept offering words.",
             HOLD_CYC);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata);
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
